// ----- sv/fcsg_pkg.sv -----
// shared types, constants and square root step for the filled circle span generator
package fcsg_pkg;

   localparam int MAX_RADIUS = 31;
   localparam int COORD_BITS = 12;
   localparam int OUT_BITS   = COORD_BITS + 2;
   localparam int RAD_BITS   = 5;
   localparam int SQ_BITS    = 2 * RAD_BITS;
   localparam int ROOT_STEPS = RAD_BITS;

   typedef struct packed {
      logic                        last;
      logic signed [OUT_BITS-1:0]  row;
      logic [COORD_BITS-1:0]       cx;
      logic [15:0]                 color;
      logic [SQ_BITS-1:0]          rem;
      logic [SQ_BITS-1:0]          root;
   } pipe_type;

   // one restoring step of the bitwise square root, bit weight 4^(ROOT_STEPS-1-idx)
   function automatic pipe_type sqrt_step(input pipe_type p, input int idx);
      pipe_type             q;
      logic [SQ_BITS-1:0]   bitv;
      logic [SQ_BITS:0]     trial;
      q     = p;
      bitv  = SQ_BITS'(1) << (2 * (ROOT_STEPS - 1 - idx));
      trial = {1'b0, p.root} + {1'b0, bitv};
      if ({1'b0, p.rem} >= trial) begin
         q.rem  = p.rem - trial[SQ_BITS-1:0];
         q.root = (p.root >> 1) + bitv;
      end else begin
         q.root = p.root >> 1;
      end
      return q;
   endfunction

endpackage

// ----- sv/filled_circle_span_generator_top.sv -----
// filled circle span generator: row sequencer feeding a five stage span pipeline
//
// A circle request beat on req_ (center, radius, color) is taken when req_valid
// is high and req_stall is low. The block then emits 2*radius+1 span beats on
// rsp_, top row first, each with inclusive start and end columns of the filled
// disc on that row, in 14-bit two's complement, unclipped. last_span marks the
// bottom row. The half-width is the floor square root of radius^2 - dy^2.
// The spans of a circle follow the request beat through the sequencer and the
// pipeline, one span per cycle while rsp_stall is low. The row sequencer holds
// req_stall high while it still issues rows of a circle, and the next request is
// taken while the last rows of the previous circle are still in the pipeline.
// Pipeline: row setup and radius^2 - dy^2, two square root steps, two more,
// the last step, then span ends into the output register.
// When rsp_stall is high with a span waiting, the whole pipeline and row issue
// hold (an idle sequencer still takes a request); nothing is lost or repeated.
// Reset (synchronous, active high) clears busy, the row count and all valid bits.
module filled_circle_span_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fcsg_pkg::COORD_BITS-1:0]     req_center_x,
   input  logic [fcsg_pkg::COORD_BITS-1:0]     req_center_y,
   input  logic [fcsg_pkg::RAD_BITS-1:0]       req_radius,
   input  logic [15:0]                         req_fill_color,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fcsg_pkg::OUT_BITS-1:0] rsp_span_row,
   output logic signed [fcsg_pkg::OUT_BITS-1:0] rsp_span_start,
   output logic signed [fcsg_pkg::OUT_BITS-1:0] rsp_span_end,
   output logic [15:0]                         rsp_span_color,
   output logic                                rsp_last_span
);
   import fcsg_pkg::*;

   logic                        busy_ff, busy_in;
   logic [RAD_BITS:0]           k_ff, k_in;
   logic [RAD_BITS-1:0]         r_ff, r_in;
   logic [COORD_BITS-1:0]       cx_ff, cx_in;
   logic [COORD_BITS-1:0]       cy_ff, cy_in;
   logic [15:0]                 color_ff, color_in;

   logic                        advance;
   logic                        accept;
   logic                        issue;
   logic                        is_last_row;

   logic signed [RAD_BITS+1:0]  dy;
   logic [RAD_BITS-1:0]         ady;
   logic [SQ_BITS-1:0]          rsq;
   logic [SQ_BITS-1:0]          dsq;
   logic [RAD_BITS-1:0]         r_sat;

   logic     va_ff, vb_ff, vc_ff, vd_ff;
   pipe_type pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in, pd_ff, pd_in;

   logic                        out_valid_ff;
   logic signed [OUT_BITS-1:0]  out_row_ff, out_start_ff, out_end_ff;
   logic signed [OUT_BITS-1:0]  out_start_in, out_end_in;
   logic [15:0]                 out_color_ff;
   logic                        out_last_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign issue     = busy_ff && advance;
   assign is_last_row = (k_ff == {r_ff, 1'b0});

   assign r_sat = (32'(req_radius) > MAX_RADIUS) ? RAD_BITS'(MAX_RADIUS) : req_radius;

   // row sequencer
   always_comb begin
      busy_in  = busy_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      if (accept) begin
         busy_in  = 1'b1;
         k_in     = '0;
         r_in     = r_sat;
         cx_in    = req_center_x;
         cy_in    = req_center_y;
         color_in = req_fill_color;
      end else if (issue) begin
         if (is_last_row) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      color_ff <= color_in;
   end

   // row setup: dy, radius^2 - dy^2
   always_comb begin
      dy    = $signed({1'b0, k_ff}) - $signed({2'b00, r_ff});
      ady   = dy[RAD_BITS+1] ? RAD_BITS'(-dy) : RAD_BITS'(dy);
      rsq   = r_ff * r_ff;
      dsq   = ady * ady;
      pa_in.last  = is_last_row;
      pa_in.row   = $signed({2'b00, cy_ff})
                    + $signed({{(OUT_BITS-RAD_BITS-2){dy[RAD_BITS+1]}}, dy});
      pa_in.cx    = cx_ff;
      pa_in.color = color_ff;
      pa_in.rem   = rsq - dsq;
      pa_in.root  = '0;
   end

   assign pb_in = sqrt_step(sqrt_step(pa_ff, 0), 1);
   assign pc_in = sqrt_step(sqrt_step(pb_ff, 2), 3);
   assign pd_in = sqrt_step(pc_ff, 4);

   assign out_start_in = $signed({2'b00, pd_ff.cx})
                         - $signed({{(OUT_BITS-RAD_BITS){1'b0}}, pd_ff.root[RAD_BITS-1:0]});
   assign out_end_in   = $signed({2'b00, pd_ff.cx})
                         + $signed({{(OUT_BITS-RAD_BITS){1'b0}}, pd_ff.root[RAD_BITS-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         va_ff        <= busy_ff;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         out_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff        <= pa_in;
         pb_ff        <= pb_in;
         pc_ff        <= pc_in;
         pd_ff        <= pd_in;
         out_row_ff   <= pd_ff.row;
         out_start_ff <= out_start_in;
         out_end_ff   <= out_end_in;
         out_color_ff <= pd_ff.color;
         out_last_ff  <= pd_ff.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_span_row   = out_row_ff;
   assign rsp_span_start = out_start_ff;
   assign rsp_span_end   = out_end_ff;
   assign rsp_span_color = out_color_ff;
   assign rsp_last_span  = out_last_ff;

   // floor root: remainder never exceeds twice the root
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> ({1'b0, pd_ff.rem} <= {pd_ff.root, 1'b0}))
      else $error("square root remainder out of range");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_start_ff <= out_end_ff))
      else $error("span start past span end");

   a_bottom_point: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_start_ff == out_end_ff))
      else $error("bottom span is not a single pixel");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && k_ff == '0))
      else $error("sequencer did not start after request");

endmodule
